FILE: hdl/i2csmq_pkg.sv
// shared types and codes for the i2c slave receive message queue
package i2csmq_pkg;

  // input command codes
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_POP   = 1'b1;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP_HDR,
    ST_POP_RD,
    ST_POP_LD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic ev_accept;
    logic pop_accept;
    logic load_done;
    logic load_empty;
    logic copy;
    logic byte_read;
    logic load_byte;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic push_start;
    logic copy_done;
    logic pop_last;
    logic out_valid;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hdl/i2c_slave_message_queue.sv
// I2C slave receive message queue: folds slave interrupt events into messages of up to
// MAX_MSG_BYTES bytes and keeps up to QUEUE_DEPTH of them for popping. One transaction is
// handled at a time, and the next is taken only once every result of the previous one has
// been taken from the output register. An event that does not push a message loads its
// result directly; one that pushes a message of L bytes gives its result once the
// single-port copy of the working message into the queue memory is done. A pop of L bytes
// gives its bytes one at a time, each after a registered read of the queue memory and
// once the output register is free; an empty pop answers with an empty result. Writing 1 to
// slave_enabled empties the queue. Queue storage holds no reset value and needs no clearing
// pass; the working message, timestamps and counters survive enable changes.
module i2c_slave_message_queue import i2csmq_pkg::*; #(
  parameter int QUEUE_DEPTH   = 64,
  parameter int MAX_MSG_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic        addressed_seen,
  input  logic        byte_ready,
  input  logic [7:0]  rx_byte,
  input  logic        access_ready,
  input  logic        overrun_seen,
  input  logic        master_open,
  input  logic        master_busy,
  input  logic [31:0] time_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  data_byte,
  output logic [4:0]  message_length,
  output logic [31:0] message_time,
  output logic        last_of_run,
  output logic [31:0] addressed_count,
  output logic [31:0] byte_count,
  output logic [31:0] boundary_count,
  output logic [31:0] message_count,
  output logic [31:0] drop_count,
  output logic [31:0] overrun_count
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  i2csmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  i2csmq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .addressed_seen   (addressed_seen),
    .byte_ready       (byte_ready),
    .rx_byte          (rx_byte),
    .access_ready     (access_ready),
    .overrun_seen     (overrun_seen),
    .master_open      (master_open),
    .master_busy      (master_busy),
    .time_now         (time_now),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .result_kind      (result_kind),
    .data_byte        (data_byte),
    .message_length   (message_length),
    .message_time     (message_time),
    .last_of_run      (last_of_run),
    .addressed_count  (addressed_count),
    .byte_count       (byte_count),
    .boundary_count   (boundary_count),
    .message_count    (message_count),
    .drop_count       (drop_count),
    .overrun_count    (overrun_count)
  );

endmodule

FILE: hdl/i2csmq_ctrl.sv
// controller state machine: sequences event, push copy and pop streaming
module i2csmq_ctrl import i2csmq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       command,
  input  dp_status_t status,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   ready;
  logic   accept;
  logic   is_pop;

  assign ready  = (state == ST_IDLE) && !status.out_valid;
  assign accept = ready && in_valid;
  assign is_pop = (command == CMD_POP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!is_pop && status.push_start) begin
            state_next = ST_PUSH;
          end else if (is_pop && !status.empty) begin
            state_next = ST_POP_HDR;
          end
        end
      end
      ST_PUSH: begin
        if (status.copy_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_POP_HDR: state_next = ST_POP_RD;
      ST_POP_RD:  state_next = ST_POP_LD;
      ST_POP_LD: begin
        if (status.out_free) begin
          state_next = status.pop_last ? ST_IDLE : ST_POP_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = !ready;
    cmd            = '0;
    cmd.ev_accept  = accept && !is_pop;
    cmd.pop_accept = accept && is_pop && !status.empty;
    cmd.load_empty = accept && is_pop && status.empty;
    case (state)
      ST_IDLE: begin
        cmd.load_done = accept && !is_pop && !status.push_start;
      end
      ST_PUSH: begin
        cmd.copy      = 1'b1;
        cmd.load_done = status.copy_done;
      end
      ST_POP_RD: begin
        cmd.byte_read = 1'b1;
      end
      ST_POP_LD: begin
        cmd.load_byte = status.out_free;
      end
      default: begin
        cmd.copy = 1'b0;
      end
    endcase
  end

endmodule

FILE: hdl/i2csmq_datapath.sv
// datapath: working message, queue memories, pointers, counters and output register
module i2csmq_datapath import i2csmq_pkg::*; #(
  parameter int QUEUE_DEPTH   = 64,
  parameter int MAX_MSG_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_write_data,
  input  logic        addressed_seen,
  input  logic        byte_ready,
  input  logic [7:0]  rx_byte,
  input  logic        access_ready,
  input  logic        overrun_seen,
  input  logic        master_open,
  input  logic        master_busy,
  input  logic [31:0] time_now,
  input  logic        out_stall,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output logic        out_valid,
  output logic [1:0]  result_kind,
  output logic [7:0]  data_byte,
  output logic [4:0]  message_length,
  output logic [31:0] message_time,
  output logic        last_of_run,
  output logic [31:0] addressed_count,
  output logic [31:0] byte_count,
  output logic [31:0] boundary_count,
  output logic [31:0] message_count,
  output logic [31:0] drop_count,
  output logic [31:0] overrun_count
);

  localparam int PW       = $clog2(2 * QUEUE_DEPTH);
  localparam int SW       = $clog2(QUEUE_DEPTH);
  localparam int LW       = $clog2(MAX_MSG_BYTES + 1);
  localparam int IW       = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
  localparam int QB_DEPTH = QUEUE_DEPTH * MAX_MSG_BYTES;
  localparam int AW       = (QB_DEPTH > 1) ? $clog2(QB_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST  = PW'(2 * QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] PTR_HALF  = PW'(QUEUE_DEPTH);
  localparam logic [PW:0]   OCC_FULL  = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [PW:0]   PTR_SPAN  = (PW + 1)'(2 * QUEUE_DEPTH);
  localparam logic [LW-1:0] LEN_MAX   = LW'(MAX_MSG_BYTES);

  function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
    slot_of = (p >= PTR_HALF) ? SW'(p - PTR_HALF) : SW'(p);
  endfunction

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] base_of(input logic [SW-1:0] s);
    base_of = AW'(s * MAX_MSG_BYTES);
  endfunction

  // memories
  logic [7:0]    work_mem  [MAX_MSG_BYTES];
  logic [7:0]    qb_mem    [QB_DEPTH];
  logic [LW-1:0] qlen_mem  [QUEUE_DEPTH];
  logic [31:0]   qtime_mem [QUEUE_DEPTH];

  logic          slave_enabled;
  logic [LW-1:0] work_length;
  logic [31:0]   work_time;
  logic [PW-1:0] head_pointer;
  logic [PW-1:0] tail_pointer;

  // push copy
  logic [SW-1:0] push_slot;
  logic [LW-1:0] push_len;
  logic [LW-1:0] cp_idx;
  logic [IW-1:0] wr_idx;
  logic          wr_valid;
  logic [7:0]    work_rd;

  // pop
  logic [SW-1:0] pop_slot;
  logic [LW-1:0] pop_idx;
  logic [LW-1:0] len_rd;
  logic [31:0]   time_rd;
  logic [7:0]    qb_rd;

  // output register
  kind_t         kind;
  logic [7:0]    data;
  logic [LW-1:0] len;
  logic [31:0]   tstamp;
  logic          last;

  logic [PW:0]   occ;
  logic          empty;
  logic          full;
  logic          byte_take;
  logic [LW-1:0] wl_app;
  logic [31:0]   time_app;
  logic          bound;
  logic          guarded;
  logic          closes;
  logic          push_start;
  logic          copy_rd;
  logic          copy_wr;
  logic          out_fire;

  assign occ = (tail_pointer >= head_pointer)
             ? (PW + 1)'(tail_pointer - head_pointer)
             : (PW + 1)'(tail_pointer) + PTR_SPAN - (PW + 1)'(head_pointer);
  assign empty = (tail_pointer == head_pointer);
  assign full  = (occ == OCC_FULL);

  // event decisions, in the order address, byte, boundary, overrun
  assign byte_take  = slave_enabled && byte_ready && (work_length < LEN_MAX);
  assign wl_app     = byte_take ? work_length + 1'b1 : work_length;
  assign time_app   = (byte_take && (work_length == '0)) ? time_now : work_time;
  assign bound      = slave_enabled && access_ready;
  assign guarded    = master_open && master_busy;
  assign closes     = bound && !guarded;
  assign push_start = closes && (wl_app != '0) && !full;

  assign copy_rd  = cmd.copy && (cp_idx < push_len);
  assign copy_wr  = cmd.copy && wr_valid;
  assign out_fire = out_valid && !out_stall;

  assign status.empty      = empty;
  assign status.push_start = push_start;
  assign status.copy_done  = (cp_idx == push_len) && !wr_valid;
  assign status.pop_last   = (pop_idx == len_rd);
  assign status.out_valid  = out_valid;
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_enabled   <= 1'b0;
      work_length     <= '0;
      work_time       <= '0;
      head_pointer    <= '0;
      tail_pointer    <= '0;
      addressed_count <= '0;
      byte_count      <= '0;
      boundary_count  <= '0;
      message_count   <= '0;
      drop_count      <= '0;
      overrun_count   <= '0;
    end else begin
      if (cmd.ev_accept) begin
        addressed_count <= addressed_count + 32'(slave_enabled && addressed_seen);
        byte_count      <= byte_count + 32'(slave_enabled && byte_ready);
        boundary_count  <= boundary_count + 32'(bound);
        message_count   <= message_count + 32'(closes && (wl_app != '0));
        drop_count      <= drop_count + 32'(bound && (guarded || (wl_app == '0)));
        overrun_count   <= overrun_count + 32'(slave_enabled && overrun_seen);
        work_length     <= closes ? '0 : wl_app;
        work_time       <= time_app;
        if (push_start) begin
          tail_pointer <= ptr_next(tail_pointer);
        end
      end
      if (cmd.pop_accept) begin
        head_pointer <= ptr_next(head_pointer);
      end
      if (cfg_write_enable) begin
        slave_enabled <= cfg_write_data;
        if (cfg_write_data) begin
          head_pointer <= '0;
          tail_pointer <= '0;
        end
      end
    end
  end

  // copy sequencing: read work byte, write it into the queue slot in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (cmd.ev_accept) begin
      wr_valid <= 1'b0;
    end else if (cmd.copy) begin
      wr_valid <= copy_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev_accept) begin
      push_slot <= slot_of(tail_pointer);
      push_len  <= wl_app;
      cp_idx    <= '0;
    end else if (copy_rd) begin
      cp_idx <= cp_idx + 1'b1;
    end
    if (copy_rd) begin
      wr_idx <= cp_idx[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev_accept && byte_take) begin
      work_mem[work_length[IW-1:0]] <= rx_byte;
    end
    if (copy_rd) begin
      work_rd <= work_mem[cp_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (copy_wr) begin
      qb_mem[base_of(push_slot) + AW'(wr_idx)] <= work_rd;
    end
    if (cmd.byte_read) begin
      qb_rd <= qb_mem[base_of(pop_slot) + AW'(pop_idx)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ev_accept && push_start) begin
      qlen_mem[slot_of(tail_pointer)]  <= wl_app;
      qtime_mem[slot_of(tail_pointer)] <= time_app;
    end
    if (cmd.pop_accept) begin
      len_rd  <= qlen_mem[slot_of(head_pointer)];
      time_rd <= qtime_mem[slot_of(head_pointer)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_accept) begin
      pop_slot <= slot_of(head_pointer);
      pop_idx  <= '0;
    end else if (cmd.byte_read) begin
      pop_idx <= pop_idx + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_done || cmd.load_empty || cmd.load_byte) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      kind   <= KIND_BYTE;
      data   <= qb_rd;
      len    <= len_rd;
      tstamp <= time_rd;
      last   <= (pop_idx == len_rd);
    end else if (cmd.load_done || cmd.load_empty) begin
      kind   <= cmd.load_empty ? KIND_EMPTY : KIND_DONE;
      data   <= '0;
      len    <= '0;
      tstamp <= '0;
      last   <= 1'b1;
    end
  end

  assign result_kind    = kind;
  assign data_byte      = data;
  assign message_length = 5'(len);
  assign message_time   = tstamp;
  assign last_of_run    = last;

endmodule

FILE: hdl/i2csmq_checker.sv
// port-level checks for the message queue, bound to the top level
module i2csmq_checker import i2csmq_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  result_kind,
  input logic [7:0]  data_byte,
  input logic [4:0]  message_length,
  input logic        last_of_run,
  input logic [31:0] addressed_count,
  input logic [31:0] byte_count,
  input logic [31:0] drop_count
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind == KIND_DONE) || (result_kind == KIND_BYTE) ||
                  (result_kind == KIND_EMPTY))
    else $error("unused result kind");

  // done and empty results are single, payload free
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind != KIND_BYTE) |->
      last_of_run && (data_byte == 8'd0) && (message_length == 5'd0))
    else $error("done or empty result with payload");

  // no new transaction while a result waits
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !out_valid)
    else $error("transaction taken with result pending");

  // counters only move on an event, never while a result is offered
  a_counters_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rst |=>
      $stable(addressed_count) && $stable(byte_count) && $stable(drop_count))
    else $error("counters changed under a pending result");

endmodule

bind i2c_slave_message_queue i2csmq_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .result_kind     (result_kind),
  .data_byte       (data_byte),
  .message_length  (message_length),
  .last_of_run     (last_of_run),
  .addressed_count (addressed_count),
  .byte_count      (byte_count),
  .drop_count      (drop_count)
);
